[sv/lph_pkg.sv]
// Shared types and constants for the linear probing hash table.
// No dependencies.
`default_nettype none
package lph_pkg;
  localparam int DEFAULT_DEPTH = 1024;
  localparam int DEFAULT_VALUE_W = 64;
  localparam int CFG_W = 11;
  localparam int CFG_RESET = 1024;
  localparam int KEY_W = 31;
  localparam int VALUE_PORT_W = 64;
  localparam int SLOT_OUT_W = 10;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RSVD      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_RD,
    S_CHK,
    S_FIN
  } state_e;

  typedef struct packed {
    logic start;
    logic done;
  } mod_ctl_t;
endpackage
`default_nettype wire

[sv/lph_mod.sv]
// Iterative restoring remainder: key modulo capacity, one key bit per cycle.
// Depends on lph_pkg.
`default_nettype none
module lph_mod import lph_pkg::*; #(
  parameter int CW = 11,
  parameter int AW = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [KEY_W-1:0] key_i,
  input  wire logic [CW-1:0] div_i,
  output mod_ctl_t           ctl_o,
  output logic [AW-1:0]      rem_o
);
  localparam int BW = $clog2(KEY_W + 1);

  logic [CW-1:0]    r_q, r_d;
  logic [KEY_W-1:0] k_q, k_d;
  logic [CW-1:0]    d_q, d_d;
  logic [BW-1:0]    n_q, n_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [CW:0]      t;

  always_comb begin
    r_d = r_q; k_d = k_q; d_d = d_q; n_d = n_q;
    busy_d = busy_q; done_d = 1'b0;
    t = {r_q, k_q[KEY_W-1]};
    if (start_i) begin
      r_d = '0; k_d = key_i; d_d = div_i; n_d = BW'(KEY_W); busy_d = 1'b1;
    end else if (busy_q) begin
      if (t >= {1'b0, d_q}) r_d = CW'(t - {1'b0, d_q});
      else r_d = CW'(t);
      k_d = {k_q[KEY_W-2:0], 1'b0};
      n_d = n_q - 1'b1;
      if (n_q == BW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; n_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; k_q <= k_d; d_q <= d_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.done  = done_q;
  assign rem_o = AW'(r_q);
endmodule
`default_nettype wire

[sv/linear_probe_hash_table.sv]
// Top level of the linear probing hash table: control FSM and slot memories.
// Depends on lph_pkg and lph_mod.
`default_nettype none
// Open-addressing hash table with linear probing. One request beat on the
// slave stream (tuser = opcode: insert, search, delete) gives one result beat
// (tuser = status). After reset a clearing pass over all TABLE_DEPTH slots
// empties the occupancy bits; no request is taken during it. A request then
// computes its home slot (key modulo capacity, one key bit per cycle in
// lph_mod) and probes slot after slot, at most capacity slots; each probe is a
// registered read of the slot memories followed by a compare. Capacity is to
// be written on the cfg channel only while idle; the block itself does not
// enforce this. 0 acts as 1, values above TABLE_DEPTH act as TABLE_DEPTH. A
// new request is taken while a finished result still waits on the master side.
module linear_probe_hash_table import lph_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH,
  parameter int VALUE_WIDTH = DEFAULT_VALUE_W
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_data_i,   // capacity_in_use
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,      // key[30:0], value_word[94:31]
  input  wire logic [1:0]  s_axis_tuser,      // opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,      // value_out[63:0], slot_index[73:64]
  output logic [1:0]       m_axis_tuser       // status
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int VW = VALUE_WIDTH;

  state_e state_q, state_d;

  // capacity register and its clamped value
  logic [CFG_W-1:0] cfg_q;
  logic [16:0]      cfg_ext;
  logic [CW-1:0]    cap;
  assign cfg_ready_o = 1'b1;
  assign cfg_ext = 17'(cfg_q);
  always_comb begin
    if (cfg_ext == 17'd0) cap = CW'(1);
    else if (cfg_ext > 17'(TABLE_DEPTH)) cap = CW'(TABLE_DEPTH);
    else cap = CW'(cfg_ext);
  end

  // request latch
  op_e              op_q;
  logic [KEY_W-1:0] key_q;
  logic [VW-1:0]    val_q;

  // probe pointers
  logic [AW-1:0] idx_q, idx_d, clr_q, clr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_nx, cnt_nx;

  // result register
  logic          ov_q, ov_d;
  status_e       rs_q, rs_d, os_q;
  logic [VW-1:0] rv_q, rv_d, ovl_q;
  logic [AW-1:0] ri_q, ri_d, oi_q;

  // slot memories: meta = {used, key}, values separate
  logic [KEY_W:0]  meta_mem [TABLE_DEPTH];
  logic [VW-1:0]   val_mem  [TABLE_DEPTH];
  logic [KEY_W:0]  meta_rd_q;
  logic [VW-1:0]   val_rd_q;
  logic            mw_en, vw_en, rd_en;
  logic [AW-1:0]   mw_addr;
  logic [KEY_W:0]  mw_data;

  mod_ctl_t      mctl;
  logic          mstart;
  logic [AW-1:0] mrem;

  lph_mod #(.CW(CW), .AW(AW)) u_mod (
    .clk_i, .rst_ni,
    .start_i(mstart),
    .key_i(s_axis_tdata[KEY_W-1:0]),
    .div_i(cap),
    .ctl_o(mctl),
    .rem_o(mrem)
  );

  logic acc, hit, used;
  assign s_axis_tready = (state_q == S_IDLE);
  assign acc  = s_axis_tvalid && s_axis_tready;
  assign used = meta_rd_q[KEY_W];
  assign idx_nx = CW'(idx_q) + CW'(1);
  assign cnt_nx = cnt_q + CW'(1);

  always_comb begin
    state_d = state_q;
    idx_d = idx_q; cnt_d = cnt_q; clr_d = clr_q;
    rs_d = rs_q; rv_d = rv_q; ri_d = ri_q;
    ov_d = ov_q;
    mstart = 1'b0;
    mw_en = 1'b0; vw_en = 1'b0; rd_en = 1'b0;
    mw_addr = idx_q; mw_data = {1'b1, key_q};
    hit = 1'b0;
    if (m_axis_tready) ov_d = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mw_en = 1'b1; mw_addr = clr_q; mw_data = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(TABLE_DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          rs_d = ST_NOT_FOUND; rv_d = '0; ri_d = '0;
          if (op_e'(s_axis_tuser) == OP_NONE) begin
            state_d = S_FIN;
          end else begin
            mstart = 1'b1;
            state_d = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mctl.done) begin
          idx_d = mrem; cnt_d = '0; state_d = S_RD;
        end
      end
      S_RD: begin
        rd_en = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (op_q == OP_INSERT) hit = !used;
        else hit = used && (meta_rd_q[KEY_W-1:0] == key_q);
        if (hit) begin
          rs_d = ST_OK; ri_d = idx_q;
          unique case (op_q)
            OP_INSERT: begin
              mw_en = 1'b1; vw_en = 1'b1;
            end
            OP_SEARCH: rv_d = val_rd_q;
            OP_DELETE: begin
              mw_en = 1'b1; mw_data = '0;
            end
            default: ;
          endcase
          state_d = S_FIN;
        end else if (cnt_nx == cap) begin
          rs_d = (op_q == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_nx;
          idx_d = (idx_nx == cap) ? '0 : AW'(idx_nx);
          state_d = S_RD;
        end
      end
      S_FIN: begin
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cfg_q <= CFG_W'(CFG_RESET);
      clr_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      ov_q <= ov_d;
      if (cfg_valid_i && cfg_ready_o) cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; cnt_q <= cnt_d;
    rs_q <= rs_d; rv_q <= rv_d; ri_q <= ri_d;
    if (acc) begin
      op_q  <= op_e'(s_axis_tuser);
      key_q <= s_axis_tdata[KEY_W-1:0];
      val_q <= s_axis_tdata[KEY_W +: VW];
    end
    if (state_q == S_FIN && (!ov_q || m_axis_tready)) begin
      os_q <= rs_q; ovl_q <= rv_q; oi_q <= ri_q;
    end
  end

  // slot memories
  always_ff @(posedge clk_i) begin
    if (mw_en) meta_mem[mw_addr] <= mw_data;
    if (rd_en) meta_rd_q <= meta_mem[idx_q];
  end
  always_ff @(posedge clk_i) begin
    if (vw_en) val_mem[idx_q] <= val_q;
    if (rd_en) val_rd_q <= val_mem[idx_q];
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = os_q;
  assign m_axis_tdata  = {6'd0, SLOT_OUT_W'(oi_q), VALUE_PORT_W'(ovl_q)};

  // checks
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> (CW'(idx_q) < cap))
    else $error("probe index beyond capacity");
  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (cnt_q < cap))
    else $error("probe count beyond one sweep");
  a_write_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mw_en |-> (state_q == S_CLEAR || state_q == S_CHK))
    else $error("slot write outside clear or check");
  a_fin_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && !ov_q) |=> (ov_q && state_q == S_IDLE))
    else $error("finished result not loaded");
  a_mod_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mctl.start |-> (state_q == S_IDLE))
    else $error("remainder started outside idle");
endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking bench for linear_probe_hash_table: stream requests, check result beats.
// Depends on lph_pkg and the RTL; a scoreboard class predicts every result.
module testbench;
  import lph_pkg::*;

  localparam int DEPTH = 1024;
  localparam int CYCLE_LIMIT = 10000000;
  localparam logic [30:0] KEY_MASK = 31'h7FFF_FFFF;

  typedef struct {
    status_e     status;
    logic [63:0] value_out;
    logic [9:0]  slot;
  } lookup_t;

  // Mirror of the table; predicts one result per accepted request.
  class table_scoreboard;
    bit          used[DEPTH];
    logic [30:0] keys[DEPTH];
    logic [63:0] vals[DEPTH];
    logic [10:0] capacity;
    lookup_t     due[$];
    int          errors;

    function new();
      capacity = 11'(CFG_RESET);
      errors = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function void set_capacity(logic [10:0] c);
      capacity = c;
    endfunction

    function int span();
      int c;
      c = capacity;
      if (c < 1) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
    endfunction

    // First empty slot or first slot holding key; -1 after a full sweep.
    function int find_slot(logic [30:0] key, bit want_empty);
      int cap, idx;
      cap = span();
      idx = key % cap;
      for (int n = 0; n < cap; n++) begin
        if (want_empty ? !used[idx] : (used[idx] && keys[idx] == key)) return idx;
        idx = (idx + 1 >= cap) ? 0 : idx + 1;
      end
      return -1;
    endfunction

    function void note_request(op_e op, logic [30:0] key, logic [63:0] val);
      lookup_t r;
      int s;
      r.status = ST_NOT_FOUND;
      r.value_out = '0;
      r.slot = '0;
      if (op == OP_INSERT) begin
        s = find_slot(key, 1'b1);
        if (s < 0) begin
          r.status = ST_FULL;
        end else begin
          used[s] = 1'b1;
          keys[s] = key;
          vals[s] = val;
          r.status = ST_OK;
          r.slot = 10'(s);
        end
      end else if (op == OP_SEARCH || op == OP_DELETE) begin
        s = find_slot(key, 1'b0);
        if (s >= 0) begin
          r.status = ST_OK;
          r.slot = 10'(s);
          if (op == OP_SEARCH) r.value_out = vals[s];
          else used[s] = 1'b0;
        end
      end
      due.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [63:0] vout, logic [9:0] slot);
      lookup_t r;
      if (due.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      r = due.pop_front();
      if (status !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, status);
        errors++;
      end
      if (vout !== r.value_out) begin
        $error("value_out: expected %h, got %h", r.value_out, vout);
        errors++;
      end
      if (slot !== r.slot) begin
        $error("slot_index: expected %0d, got %0d", r.slot, slot);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        cfg_valid_i, cfg_ready_o;
  logic [10:0] cfg_data_i;
  logic        s_axis_tvalid, s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  table_scoreboard sb;
  int send_idle, recv_idle;  // idle chance in percent
  int cycles;

  linear_probe_hash_table dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random backpressure, check each accepted beat.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(0, 99) >= recv_idle);
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[73:64]);
    end
  end

  task automatic send_req(op_e op, logic [30:0] key, logic [63:0] val);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = {1'b0, val, key};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, key, val);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Capacity changes only with the table idle.
  task automatic write_capacity(logic [10:0] c);
    drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = c;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_capacity(c);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [63:0] rand_val();
    return {$urandom(), $urandom()};
  endfunction

  function automatic op_e rand_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return OP_INSERT;
    if (r < 70) return OP_SEARCH;
    if (r < 95) return OP_DELETE;
    return OP_NONE;
  endfunction

  initial begin
    logic [10:0] caps[12];
    int          counts[12];
    logic [30:0] pool[8];
    logic [30:0] k;
    int          capeff, home;

    caps = '{11'd4, 11'd16, 11'd64, 11'd7, 11'd1, 11'd128,
             11'd31, 11'd2, 11'd1024, 11'd250, 11'd0, 11'd2047};
    counts = '{50, 50, 50, 50, 30, 50, 50, 40, 40, 50, 30, 37};
    sb = new();
    cycles = 0;
    send_idle = 0;
    recv_idle = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_NONE;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: key and value extremes, every opcode, missing key at full size.
    write_capacity(11'd1024);
    send_req(OP_INSERT, 31'd0, 64'd0);
    send_req(OP_INSERT, KEY_MASK, '1);
    send_req(OP_SEARCH, KEY_MASK, '0);
    send_req(OP_SEARCH, 31'd0, '1);
    send_req(OP_SEARCH, 31'd12345, '0);
    send_req(OP_DELETE, KEY_MASK, '0);
    send_req(OP_DELETE, KEY_MASK, '0);
    send_req(OP_NONE, 31'd0, '1);
    // Single slot: second insert finds the table full.
    write_capacity(11'd1);
    send_req(OP_INSERT, 31'd9, 64'hA5A5_5A5A_F00D_BEEF);
    send_req(OP_INSERT, 31'd10, 64'd1);
    send_req(OP_SEARCH, 31'd9, '0);
    send_req(OP_DELETE, 31'd9, '0);
    send_req(OP_SEARCH, 31'd9, '0);
    // Zero acts as one slot.
    write_capacity(11'd0);
    send_req(OP_INSERT, 31'd77, 64'd5);
    send_req(OP_INSERT, 31'd77, 64'd6);
    // Three slots: probe wraps, delete leaves a hole the search steps over.
    write_capacity(11'd3);
    send_req(OP_INSERT, 31'd2, 64'd1);
    send_req(OP_INSERT, 31'd5, 64'd2);
    send_req(OP_INSERT, 31'd8, 64'd3);
    send_req(OP_INSERT, 31'd11, 64'd4);
    send_req(OP_DELETE, 31'd5, '0);
    send_req(OP_SEARCH, 31'd8, '0);
    // Lowered capacity hides upper slots.
    write_capacity(11'd2);
    send_req(OP_SEARCH, 31'd2, '0);
    send_req(OP_SEARCH, 31'd0, '0);

    // Random phases, colliding key pools per capacity.
    foreach (caps[p]) begin
      case (p * 3 / 12)
        0: begin send_idle = 32; recv_idle = 78; end
        1: begin send_idle = 78; recv_idle = 32; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      write_capacity(caps[p]);
      capeff = sb.span();
      home = $urandom_range(0, capeff - 1);
      foreach (pool[i])
        pool[i] = 31'(($urandom_range(0, 2000000) * capeff + home + (i % 3)));
      for (int n = 0; n < counts[p]; n++) begin
        if ($urandom_range(0, 99) < 85) k = pool[$urandom_range(0, 7)];
        else k = 31'($urandom()) & KEY_MASK;
        send_req(rand_op(), k, rand_val());
      end
    end

    drain();
    repeat (2200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
